// ===== hw/rtl/cir_pkg.sv =====
// Package with shared constants and types for the insertion router.
package cir_pkg;

    // Default sizes of the route storage.
    localparam int MaxStopsDef    = 31;
    localparam int NumVehiclesDef = 4;

    // Field widths.
    localparam int CellW = 8;
    localparam int GridW = 5;
    localparam int PosW  = 5;
    localparam int CostW = 11;
    localparam int SumW  = 24;

    // Configuration register indexes.
    localparam logic [1:0] REG_GRID  = 2'd0;
    localparam logic [1:0] REG_DEPOT = 2'd1;
    localparam logic [1:0] REG_CAP   = 2'd2;

    // Request codes.
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Saturation limit of the reported cost.
    localparam logic [CostW-1:0] COST_MAX = 11'd2047;

    // Row and column of one cell, as produced by the cell splitter.
    typedef struct packed {
        logic [CellW-1:0] row;
        logic [CellW-1:0] col;
    } t_rc;

endpackage

// ===== hw/rtl/cir_divider.sv =====
// Iterative cell splitter: divides an 8-bit cell by the grid side, one bit a cycle.
module cir_divider
    import cir_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CellW-1:0] i_cell,
    input  logic [GridW-1:0] i_side,
    output logic             o_done,
    output t_rc              o_rc
);

    logic [CellW-1:0] r_quo, n_quo;
    logic [GridW:0]   r_rem, n_rem;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [GridW:0]   w_trial;

    // One restoring-division step per cycle.
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[GridW-1:0], r_quo[CellW-1]};
        if (i_start) begin
            n_quo  = i_cell;
            n_rem  = '0;
            n_cnt  = 4'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_side}) begin
                n_rem = w_trial - {1'b0, i_side};
                n_quo = {r_quo[CellW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[CellW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'(CellW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_done   = r_done;
    assign o_rc.row = r_quo;
    assign o_rc.col = CellW'(r_rem);

endmodule

// ===== hw/rtl/cheapest_insertion_router_core.sv =====
// Top level of the cheapest-insertion router: route memory, sequencer and output.
//
// Usage: raise start with a request while busy is low; the transaction is taken
// at that clock edge. An append writes one stop into the vehicle's list at the
// accepting edge, produces no result and leaves busy low, so the next request
// can follow in the next cycle. An insert scores the customer at every position
// of the list, rewrites the list and emits the new route on o_valid, one stop
// per result, with o_last on the final stop; a full list gives one
// status result in the cycle after acceptance instead, and busy stays low.
// Configuration is written on i_cfg_we/i_cfg_idx/i_cfg_data while idle; the user
// is bound to this, and the block itself does not enforce it. Each leg splits both
// end cells with the iterative divider, and a depot detour adds a leg. With n
// stored stops an insert runs n+1 trials of n+1 legs, plus any detours, then
// the rewrite and the emission. The divider and the single read port set the
// run time.
// Reset clears the route lengths, configuration, state and result strobe; the stop memory is not cleared.
// Results cannot be held off: the receiver takes each one in the cycle shown.
module cheapest_insertion_router_core
    import cir_pkg::*;
#(
    parameter int MAX_STOPS    = MaxStopsDef,
    parameter int NUM_VEHICLES = NumVehiclesDef
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_req_type,
    input  logic [1:0]       i_vehicle_id,
    input  logic [CellW-1:0] i_target_cell,
    input  logic [CellW-1:0] i_vehicle_cell,
    input  logic [7:0]       i_capacity_left,
    input  logic             i_clear_route,
    output logic             o_valid,
    output logic [CellW-1:0] o_stop_cell,
    output logic [PosW-1:0]  o_insert_position,
    output logic [CostW-1:0] o_best_cost,
    output logic             o_status,
    output logic             o_last
);

    localparam int Depth = MAX_STOPS * NUM_VEHICLES;
    localparam int AddrW = $clog2(Depth);
    localparam int LenW  = $clog2(MAX_STOPS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TRIAL  = 4'd1;
    localparam logic [3:0] S_FETCH  = 4'd2;
    localparam logic [3:0] S_STEP   = 4'd3;
    localparam logic [3:0] S_DIVW   = 4'd4;
    localparam logic [3:0] S_ADD    = 4'd5;
    localparam logic [3:0] S_TEND   = 4'd6;
    localparam logic [3:0] S_WRITE  = 4'd7;
    localparam logic [3:0] S_WRRD   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_EMRD   = 4'd10;

    // Configuration registers.
    logic [GridW-1:0] r_grid;
    logic [CellW-1:0] r_depot;
    logic [7:0]       r_vcap;
    logic [GridW-1:0] w_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid  <= 5'd10;
            r_depot <= '0;
            r_vcap  <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID:  r_grid  <= i_cfg_data[GridW-1:0];
                REG_DEPOT: r_depot <= i_cfg_data;
                REG_CAP:   r_vcap  <= i_cfg_data;
                default:   ;
            endcase
        end
    end
    assign w_side = (r_grid < 5'd2) ? 5'd2 : r_grid;

    // Route lengths, one per vehicle.
    logic [LenW-1:0] r_len [NUM_VEHICLES];

    // Stop memory with one registered read port and one write port.
    logic [CellW-1:0] r_mem [Depth];
    logic [AddrW-1:0] w_raddr, w_waddr;
    logic             w_we;
    logic [CellW-1:0] w_wdata, r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    // Request registers.
    logic [3:0]       r_state;
    logic [AddrW-1:0] r_base;
    logic [LenW-1:0]  r_n;
    logic [CellW-1:0] r_cell, r_vcell, r_cur;
    logic [7:0]       r_capl, r_cap;
    logic [LenW-1:0]  r_pos, r_k, r_j, r_bpos;
    logic [SumW-1:0]  r_total, r_best;
    logic             r_detour;
    logic [CellW-1:0] r_dest;
    t_rc              r_rc_a;
    logic             r_phase;
    logic [1:0]       r_vid;

    // Cell splitter shared by both ends of a leg.
    logic             w_dstart;
    logic [CellW-1:0] w_dcell;
    logic             w_ddone;
    t_rc              w_rc;

    cir_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_cell  (w_dcell),
        .i_side  (w_side),
        .o_done  (w_ddone),
        .o_rc    (w_rc)
    );

    // Trial cell at position r_k: the customer, or the stored stop.
    logic [CellW-1:0] w_tcell;
    assign w_tcell = (r_k == r_pos) ? r_cell : r_rdata;

    // Read address of the next stored stop (slot r_j).
    assign w_raddr = r_base + AddrW'(r_j);

    logic [CellW-1:0] w_dr, w_dc;
    assign w_dr = (r_rc_a.row > w_rc.row) ? r_rc_a.row - w_rc.row : w_rc.row - r_rc_a.row;
    assign w_dc = (r_rc_a.col > w_rc.col) ? r_rc_a.col - w_rc.col : w_rc.col - r_rc_a.col;

    logic w_acc, w_idle_ok;
    assign w_idle_ok = (r_state == S_IDLE);
    assign w_acc     = start && w_idle_ok;
    assign busy      = !w_idle_ok;

    logic [AddrW-1:0] w_vbase;
    assign w_vbase = AddrW'(i_vehicle_id) * AddrW'(MAX_STOPS);

    // An insert that cannot be served answers with a status only.
    logic w_full_ins;
    assign w_full_ins = (i_vehicle_id >= NUM_VEHICLES) ||
                        (r_len[i_vehicle_id] >= LenW'(MAX_STOPS));

    // Registered result fields.
    logic [CellW-1:0] r_ocell;
    logic             r_ovalid, r_olast, r_ostat;
    logic [CostW-1:0] r_ocost;
    logic [PosW-1:0]  r_opos;

    always_comb begin
        w_dstart = 1'b0;
        w_dcell  = r_cur;
        w_we     = 1'b0;
        w_waddr  = r_base + AddrW'(r_k);
        w_wdata  = r_rdata;
        if (r_state == S_STEP) begin
            w_dstart = 1'b1;
            w_dcell  = r_cur;
        end else if (r_state == S_DIVW && w_ddone && !r_phase) begin
            w_dstart = 1'b1;
            w_dcell  = r_dest;
        end
        if (r_state == S_WRRD) begin
            w_we    = 1'b1;
            w_wdata = (r_k == r_bpos) ? r_cell : r_rdata;
        end
        if (r_state == S_IDLE && w_acc && i_req_type == REQ_APPEND &&
            i_vehicle_id < NUM_VEHICLES) begin
            w_we    = (i_clear_route || r_len[i_vehicle_id] < LenW'(MAX_STOPS));
            w_waddr = w_vbase + (i_clear_route ? '0 : AddrW'(r_len[i_vehicle_id]));
            w_wdata = i_target_cell;
        end
    end

    // Result strobe: a full-route status registered at acceptance, or one route stop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= (w_acc && i_req_type == REQ_INSERT && w_full_ins) ||
                        (r_state == S_EMRD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int v = 0; v < NUM_VEHICLES; v++) r_len[v] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_base  <= w_vbase;
                        r_vid   <= i_vehicle_id;
                        r_cell  <= i_target_cell;
                        r_vcell <= i_vehicle_cell;
                        r_capl  <= i_capacity_left;
                        if (i_req_type == REQ_APPEND) begin
                            if (i_vehicle_id < NUM_VEHICLES) begin
                                if (i_clear_route) r_len[i_vehicle_id] <= LenW'(1);
                                else if (r_len[i_vehicle_id] < LenW'(MAX_STOPS))
                                    r_len[i_vehicle_id] <= r_len[i_vehicle_id] + 1'b1;
                            end
                        end else if (w_full_ins) begin
                            r_ocell  <= '0;
                            r_opos   <= '0;
                            r_ocost  <= '0;
                            r_ostat  <= 1'b1;
                            r_olast  <= 1'b1;
                        end else begin
                            r_n     <= r_len[i_vehicle_id];
                            r_pos   <= '0;
                            r_best  <= '1;
                            r_state <= S_TRIAL;
                        end
                    end
                end
                // Start a trial route for position r_pos.
                S_TRIAL: begin
                    r_k      <= '0;
                    r_j      <= '0;
                    r_total  <= '0;
                    r_cur    <= r_vcell;
                    r_cap    <= r_capl;
                    r_detour <= 1'b0;
                    r_state  <= S_FETCH;
                end
                // Stored stop for slot r_j is read here.
                S_FETCH: r_state <= S_STEP;
                // Choose the next leg's destination; a detour is followed by the stop.
                S_STEP: begin
                    r_phase <= 1'b0;
                    if (r_cap == 8'd0 && !r_detour) begin
                        r_detour <= 1'b1;
                        r_dest   <= r_depot;
                    end else begin
                        r_detour <= 1'b0;
                        r_dest   <= w_tcell;
                    end
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_ddone) begin
                        if (!r_phase) begin
                            r_rc_a  <= w_rc;
                            r_phase <= 1'b1;
                        end else begin
                            r_state <= S_ADD;
                        end
                    end
                end
                // Accumulate one leg.
                S_ADD: begin
                    r_total <= r_total + SumW'(w_dr) + SumW'(w_dc);
                    r_cur   <= r_dest;
                    if (r_detour) begin
                        r_cap   <= r_vcap;
                        r_state <= S_STEP;
                    end else begin
                        if (r_cap != 8'd0) r_cap <= r_cap - 8'd1;
                        if (r_k != r_pos) r_j <= r_j + 1'b1;
                        r_k <= r_k + 1'b1;
                        r_state <= (r_k == r_n) ? S_TEND : S_FETCH;
                    end
                end
                S_TEND: begin
                    if (r_total < r_best) begin
                        r_best <= r_total;
                        r_bpos <= r_pos;
                    end
                    if (r_pos == r_n) begin
                        r_k     <= r_n;
                        r_j     <= r_n - 1'b1;
                        r_state <= S_WRITE;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_TRIAL;
                    end
                end
                // Rewrite from the end: slot k takes slot k-1 above bpos.
                S_WRITE: r_state <= S_WRRD;
                S_WRRD: begin
                    if (r_k == r_bpos) begin
                        r_len[r_vid] <= r_n + 1'b1;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_j     <= r_j - 1'b1;
                        r_state <= S_WRITE;
                    end
                end
                S_EMIT: r_state <= S_EMRD;
                S_EMRD: begin
                    r_ocell  <= r_rdata;
                    r_opos   <= PosW'(r_bpos);
                    r_ocost  <= (r_best > SumW'(COST_MAX)) ? COST_MAX : r_best[CostW-1:0];
                    r_ostat  <= 1'b0;
                    r_olast  <= (r_k == r_n);
                    r_k      <= r_k + 1'b1;
                    r_j      <= r_j + 1'b1;
                    r_state  <= (r_k == r_n) ? S_IDLE : S_EMIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_stop_cell       = r_ocell;
    assign o_insert_position = r_opos;
    assign o_best_cost       = r_ocost;
    assign o_status          = r_ostat;
    assign o_last            = r_olast;

endmodule

// ===== hw/rtl/cir_checker.sv =====
// Port checker for the insertion router, bound to the top level.
module cir_checker
    import cir_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input logic             o_status,
    input logic             o_last,
    input logic [CostW-1:0] o_best_cost
);

    // A full-route status is always the only result of its transaction.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last) else $error("status without last");

    // A status result carries zero cost.
    a_status_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_best_cost == '0) else $error("status cost");

    // Route results only appear while busy or just after.
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status && !o_last |-> busy) else $error("result idle");

endmodule

bind cheapest_insertion_router_core cir_checker u_cir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_last      (o_last),
    .o_best_cost (o_best_cost)
);
